// ===== hw/rtl/wnps_pkg.sv =====
// ----------------------------------------------------------------------------
// wnps_pkg
// shared types and constants for the wildcard nibble pattern scan core
// ----------------------------------------------------------------------------
package wnps_pkg;

    localparam int PATTERN_BYTES = 8;
    localparam int WIN_W         = 8 * PATTERN_BYTES;
    localparam int LEN_W         = 4;
    localparam int LEN_IDX_W     = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int COUNT_W       = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CARE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] match_offset;
    } out_item_t;

    typedef struct packed {
        logic [WIN_W-1:0] value;
        logic [WIN_W-1:0] care;
        logic [LEN_W-1:0] length;
    } pattern_cfg_t;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] offset;
    } match_t;

endpackage

// ===== hw/rtl/wildcard_nibble_pattern_scan_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_nibble_pattern_scan_core
// finds the first place in each byte buffer where a wildcard nibble
// signature matches, and reports its start offset or not found
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------
//   in      | in_valid / in_stall    | in_data  (data_byte, last_byte)
//   out     | out_valid / out_stall  | out_data (found, match_offset)
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one byte per cycle; a result appears in the output register the cycle
// after the byte that causes it, set by the window shift and masked compare
// reset clears the window, byte counter, match flag, config and output valid
// in_stall rises only while a result sits in the output register and the
// downstream side stalls it; a taken result frees the register in that cycle
// the config port is always ready
// ----------------------------------------------------------------------------
module wildcard_nibble_pattern_scan_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte stream in
    input  logic                                in_valid,
    output logic                                in_stall,
    input  wnps_pkg::in_item_t                  in_data,
    // results out
    output logic                                out_valid,
    input  logic                                out_stall,
    output wnps_pkg::out_item_t                 out_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wnps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wnps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wnps_pkg::pattern_cfg_t         pattern;
    wnps_pkg::match_t               match;

    // per-buffer scan state
    logic [wnps_pkg::WIN_W-1:0]     window_reg;
    logic [wnps_pkg::WIN_W-1:0]     window_next;
    logic [wnps_pkg::COUNT_W-1:0]   count_reg;
    logic [wnps_pkg::COUNT_W-1:0]   count_next;
    logic                           seen_reg;

    // output register
    logic                           out_valid_reg;
    wnps_pkg::out_item_t            out_data_reg;

    logic                           in_accept;
    logic                           out_taken;
    logic                           emit_hit;
    logic                           emit_miss;

    wnps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern)
    );

    // window after this byte: newest byte in the low bits
    assign window_next = {window_reg[wnps_pkg::WIN_W-9:0], in_data.data_byte};

    // byte counter saturates at all ones
    assign count_next = (&count_reg) ? count_reg : count_reg + wnps_pkg::COUNT_W'(1);

    wnps_match u_match (
        .pattern (pattern),
        .window  (window_next),
        .count   (count_next),
        .result  (match)
    );

    // output register is free when empty or being drained this cycle
    assign out_taken = out_valid_reg && !out_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // first match reports found; a buffer ending with no match reports miss
    assign emit_hit  = in_accept && !seen_reg && match.hit;
    assign emit_miss = in_accept && !seen_reg && !match.hit && in_data.last_byte;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (in_data.last_byte)
                begin
                    // buffer done, start clean for the next one
                    window_reg <= '0;
                    count_reg  <= '0;
                    seen_reg   <= 1'b0;
                end
                else
                begin
                    window_reg <= window_next;
                    count_reg  <= count_next;
                    seen_reg   <= seen_reg || match.hit;
                end
            end

            if (emit_hit || emit_miss)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit_hit)
        begin
            out_data_reg.found        <= 1'b1;
            out_data_reg.match_offset <= match.offset;
        end
        else if (emit_miss)
        begin
            out_data_reg.found        <= 1'b0;
            out_data_reg.match_offset <= '0;
        end
    end

endmodule

// ===== hw/rtl/wnps_cfg.sv =====
// ----------------------------------------------------------------------------
// wnps_cfg
// configuration registers: pattern value, care mask and length
// ----------------------------------------------------------------------------
module wnps_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wnps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wnps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wnps_pkg::pattern_cfg_t              pattern
);

    wnps_pkg::pattern_cfg_t pattern_reg;

    assign cfg_ready = 1'b1;
    assign pattern   = pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wnps_pkg::REG_PATTERN_VALUE:
                    pattern_reg.value <= cfg_data[wnps_pkg::WIN_W-1:0];
                wnps_pkg::REG_PATTERN_CARE:
                    pattern_reg.care <= cfg_data[wnps_pkg::WIN_W-1:0];
                wnps_pkg::REG_PATTERN_LENGTH:
                    pattern_reg.length <= cfg_data[wnps_pkg::LEN_W-1:0];
                default:
                    pattern_reg <= pattern_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/wnps_match.sv =====
// ----------------------------------------------------------------------------
// wnps_match
// masked compare of the byte window against the pattern at every length
// ----------------------------------------------------------------------------
module wnps_match (
    input  wnps_pkg::pattern_cfg_t              pattern,
    input  logic [wnps_pkg::WIN_W-1:0]          window,
    input  logic [wnps_pkg::COUNT_W-1:0]        count,
    output wnps_pkg::match_t                    result
);

    logic [wnps_pkg::PATTERN_BYTES-1:0] hit_by_len;
    logic [wnps_pkg::LEN_W-1:0]         len_m1;
    logic                               len_ok;
    logic                               enough;

    // hit_by_len[L-1]: window matches a pattern of L bytes, oldest byte first
    always_comb
    begin
        for (int l = 1; l <= wnps_pkg::PATTERN_BYTES; l++)
        begin
            hit_by_len[l-1] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (((pattern.value[8*k +: 8] ^ window[8*(l-1-k) +: 8])
                     & pattern.care[8*k +: 8]) != 8'h00)
                begin
                    hit_by_len[l-1] = 1'b0;
                end
            end
        end
    end

    assign len_m1 = pattern.length - wnps_pkg::LEN_W'(1);
    assign len_ok = (pattern.length != '0) &&
                    (pattern.length <= wnps_pkg::LEN_W'(wnps_pkg::PATTERN_BYTES));
    assign enough = (count >= wnps_pkg::COUNT_W'(pattern.length));

    assign result.hit    = len_ok && enough && hit_by_len[len_m1[wnps_pkg::LEN_IDX_W-1:0]];
    assign result.offset = count - wnps_pkg::COUNT_W'(pattern.length);

endmodule
